// File: rtl/h2r_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// Used by h2r_div_full and hsv_to_rgb_pixel; depends on nothing else.

package h2r_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 9;
    localparam int REM_BITS     = 6;
    localparam int COUNT_BITS   = 4;
    localparam int SCALE_BITS   = 14;
    localparam int PROD_BITS    = CHANNEL_BITS + SCALE_BITS;
    localparam int PRE_SHIFT    = 2;
    localparam int QUOT_BITS    = PROD_BITS - PRE_SHIFT;
    localparam int RECIP_SHIFT  = 32;
    localparam int RECIP_BITS   = 21;
    localparam int RESID_BITS   = 13;

    localparam logic [CHANNEL_BITS-1:0] CHANNEL_MAX = 8'd255;
    localparam logic [REM_BITS-1:0]     SECTOR_DEG  = 6'd60;
    localparam logic [SCALE_BITS-1:0]   FULL_SCALE  = 14'd15300;

    // 15300 = 4 * 3825; the divide by four is a shift, the rest uses a reciprocal.
    localparam longint unsigned         DIV_BASE_L = 64'd3825;
    localparam logic [RESID_BITS-1:0]   DIV_BASE   = 13'd3825;
    localparam logic [RECIP_BITS-1:0]   RECIP      =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / DIV_BASE_L);

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } h2r_sector_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue_deg;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_pixel_t;

    // Load enables for the two divider stages.
    typedef struct packed {
        logic est;
        logic fix;
    } h2r_div_en_t;

endpackage

// File: rtl/h2r_div_full.sv
// Two-stage floor division of a product by the full scale 15300.
// Depends on h2r_pkg for widths, the reciprocal and the enable struct.

module h2r_div_full (
    input  logic                                clk,
    input  h2r_pkg::h2r_div_en_t                en,
    input  logic [h2r_pkg::PROD_BITS-1:0]       dividend,
    output logic [h2r_pkg::CHANNEL_BITS-1:0]    quotient
);

    logic [h2r_pkg::QUOT_BITS-1:0]                      quar;
    logic [h2r_pkg::QUOT_BITS+h2r_pkg::RECIP_BITS-1:0]  recip_prod;
    logic [h2r_pkg::QUOT_BITS-1:0]                      quar_reg;
    logic [h2r_pkg::CHANNEL_BITS-1:0]                   est_next;
    logic [h2r_pkg::CHANNEL_BITS-1:0]                   est_reg;
    logic [h2r_pkg::QUOT_BITS-1:0]                      back_prod;
    logic [h2r_pkg::QUOT_BITS-1:0]                      resid_full;
    logic [h2r_pkg::RESID_BITS-1:0]                     resid;
    logic [h2r_pkg::CHANNEL_BITS-1:0]                   quot_next;
    logic [h2r_pkg::CHANNEL_BITS-1:0]                   quot_reg;

    // The reciprocal is rounded down, so the estimate is the quotient or one less.
    always_comb
    begin
        quar       = dividend[h2r_pkg::PROD_BITS-1:h2r_pkg::PRE_SHIFT];
        recip_prod = (h2r_pkg::QUOT_BITS+h2r_pkg::RECIP_BITS)'(quar)
                   * (h2r_pkg::QUOT_BITS+h2r_pkg::RECIP_BITS)'(h2r_pkg::RECIP);
        est_next   = recip_prod[h2r_pkg::RECIP_SHIFT +: h2r_pkg::CHANNEL_BITS];
    end

    always_comb
    begin
        back_prod  = h2r_pkg::QUOT_BITS'(est_reg) * h2r_pkg::QUOT_BITS'(h2r_pkg::DIV_BASE);
        resid_full = quar_reg - back_prod;
        resid      = resid_full[h2r_pkg::RESID_BITS-1:0];
        quot_next  = est_reg + h2r_pkg::CHANNEL_BITS'(resid >= h2r_pkg::DIV_BASE);
    end

    always_ff @(posedge clk)
    begin
        if (en.est)
        begin
            quar_reg <= quar;
            est_reg  <= est_next;
        end
        if (en.fix)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quotient = quot_reg;

endmodule

// File: rtl/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter, six register stages.
// An accepted input passes through stages 1 to 6 in order to output valid.
// Throughput: one pixel per cycle; each stage holds when the one after it is
// full and stalled, so a stall only backs up as far as the first empty stage.
// Reset clears the stage valid bits only; the data registers are not reset.
// Depends on h2r_pkg and h2r_div_full.

module hsv_to_rgb_pixel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hsv_valid,
    output logic                hsv_ready,
    input  h2r_pkg::hsv_pixel_t hsv,
    output logic                rgb_valid,
    input  logic                rgb_ready,
    output h2r_pkg::rgb_pixel_t rgb
);

    localparam int STAGES = 6;
    localparam int CB     = h2r_pkg::CHANNEL_BITS;

    logic [STAGES:1]   vld_reg;
    logic [STAGES+1:1] adv;

    // Stage 1: sector and remainder of the hue.
    logic [h2r_pkg::COUNT_BITS-1:0]  hue_count;
    logic [h2r_pkg::HUE_BITS-1:0]    hue_base;
    logic [h2r_pkg::HUE_BITS-1:0]    hue_diff;
    h2r_pkg::h2r_sector_t            sec1_next;
    h2r_pkg::h2r_sector_t            sec1_reg;
    logic [h2r_pkg::REM_BITS-1:0]    rem1_next;
    logic [h2r_pkg::REM_BITS-1:0]    rem1_reg;
    logic [CB-1:0]                   sat1_reg;
    logic [CB-1:0]                   val1_reg;

    // Stage 2: numerators of p, q and t.
    logic [h2r_pkg::SCALE_BITS-1:0]  sq_prod;
    logic [h2r_pkg::SCALE_BITS-1:0]  st_prod;
    h2r_pkg::h2r_sector_t            sec2_reg;
    logic [CB-1:0]                   val2_reg;
    logic [CB-1:0]                   np2_next;
    logic [CB-1:0]                   np2_reg;
    logic [h2r_pkg::SCALE_BITS-1:0]  nq2_next;
    logic [h2r_pkg::SCALE_BITS-1:0]  nq2_reg;
    logic [h2r_pkg::SCALE_BITS-1:0]  nt2_next;
    logic [h2r_pkg::SCALE_BITS-1:0]  nt2_reg;

    // Stage 3: products with the value channel.
    h2r_pkg::h2r_sector_t            sec3_reg;
    logic [CB-1:0]                   val3_reg;
    logic [2*CB-1:0]                 pp3_next;
    logic [2*CB-1:0]                 pp3_reg;
    logic [h2r_pkg::PROD_BITS-1:0]   pq3_next;
    logic [h2r_pkg::PROD_BITS-1:0]   pq3_reg;
    logic [h2r_pkg::PROD_BITS-1:0]   pt3_next;
    logic [h2r_pkg::PROD_BITS-1:0]   pt3_reg;

    // Stages 4 and 5: divisions.
    logic [2*CB:0]                   p_sum;
    h2r_pkg::h2r_sector_t            sec4_reg;
    logic [CB-1:0]                   val4_reg;
    logic [CB-1:0]                   p4_reg;
    h2r_pkg::h2r_sector_t            sec5_reg;
    logic [CB-1:0]                   val5_reg;
    logic [CB-1:0]                   p5_reg;
    logic [CB-1:0]                   q5;
    logic [CB-1:0]                   t5;
    h2r_pkg::h2r_div_en_t            div_en;

    // Stage 6: routing into the output register.
    h2r_pkg::rgb_pixel_t             rgb_next;
    h2r_pkg::rgb_pixel_t             rgb_reg;

    // A stage may load when it is empty or when its content moves on.
    always_comb
    begin
        adv[STAGES+1] = rgb_ready;
        for (int k = STAGES; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign hsv_ready = adv[1];
    assign rgb_valid = vld_reg[STAGES];
    assign rgb       = rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= hsv_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Hues of 360 and above count past five and fall into the last sector.
    always_comb
    begin
        hue_count = '0;
        for (int k = 1; k <= 8; k++)
        begin
            hue_count = hue_count + h2r_pkg::COUNT_BITS'(
                hsv.hue_deg >= h2r_pkg::HUE_BITS'(k * 60));
        end
        hue_base  = h2r_pkg::HUE_BITS'(hue_count) * h2r_pkg::HUE_BITS'(h2r_pkg::SECTOR_DEG);
        hue_diff  = hsv.hue_deg - hue_base;
        rem1_next = hue_diff[h2r_pkg::REM_BITS-1:0];
        if (hue_count >= h2r_pkg::COUNT_BITS'(h2r_pkg::SEC_MAG_RED))
        begin
            sec1_next = h2r_pkg::SEC_MAG_RED;
        end
        else
        begin
            sec1_next = h2r_pkg::h2r_sector_t'(hue_count[2:0]);
        end
    end

    always_comb
    begin
        sq_prod  = h2r_pkg::SCALE_BITS'(sat1_reg) * h2r_pkg::SCALE_BITS'(rem1_reg);
        st_prod  = h2r_pkg::SCALE_BITS'(sat1_reg)
                 * h2r_pkg::SCALE_BITS'(h2r_pkg::SECTOR_DEG - rem1_reg);
        np2_next = h2r_pkg::CHANNEL_MAX - sat1_reg;
        nq2_next = h2r_pkg::FULL_SCALE - sq_prod;
        nt2_next = h2r_pkg::FULL_SCALE - st_prod;
    end

    always_comb
    begin
        pp3_next = (2*CB)'(val2_reg) * (2*CB)'(np2_reg);
        pq3_next = h2r_pkg::PROD_BITS'(val2_reg) * h2r_pkg::PROD_BITS'(nq2_reg);
        pt3_next = h2r_pkg::PROD_BITS'(val2_reg) * h2r_pkg::PROD_BITS'(nt2_reg);
    end

    // Exact floor division by 255 for any product of two 8-bit channels.
    assign p_sum = (2*CB+1)'(pp3_reg) + (2*CB+1)'(pp3_reg >> CB) + (2*CB+1)'(1);

    assign div_en.est = adv[4];
    assign div_en.fix = adv[5];

    h2r_div_full u_div_q (
        .clk      (clk),
        .en       (div_en),
        .dividend (pq3_reg),
        .quotient (q5)
    );

    h2r_div_full u_div_t (
        .clk      (clk),
        .en       (div_en),
        .dividend (pt3_reg),
        .quotient (t5)
    );

    always_comb
    begin
        unique case (sec5_reg)
            h2r_pkg::SEC_RED_YEL:
            begin
                rgb_next.red = val5_reg; rgb_next.green = t5;       rgb_next.blue = p5_reg;
            end
            h2r_pkg::SEC_YEL_GRN:
            begin
                rgb_next.red = q5;       rgb_next.green = val5_reg; rgb_next.blue = p5_reg;
            end
            h2r_pkg::SEC_GRN_CYN:
            begin
                rgb_next.red = p5_reg;   rgb_next.green = val5_reg; rgb_next.blue = t5;
            end
            h2r_pkg::SEC_CYN_BLU:
            begin
                rgb_next.red = p5_reg;   rgb_next.green = q5;       rgb_next.blue = val5_reg;
            end
            h2r_pkg::SEC_BLU_MAG:
            begin
                rgb_next.red = t5;       rgb_next.green = p5_reg;   rgb_next.blue = val5_reg;
            end
            default:
            begin
                rgb_next.red = val5_reg; rgb_next.green = p5_reg;   rgb_next.blue = q5;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sec1_reg <= sec1_next;
            rem1_reg <= rem1_next;
            sat1_reg <= hsv.saturation;
            val1_reg <= hsv.brightness;
        end
        if (adv[2])
        begin
            sec2_reg <= sec1_reg;
            val2_reg <= val1_reg;
            np2_reg  <= np2_next;
            nq2_reg  <= nq2_next;
            nt2_reg  <= nt2_next;
        end
        if (adv[3])
        begin
            sec3_reg <= sec2_reg;
            val3_reg <= val2_reg;
            pp3_reg  <= pp3_next;
            pq3_reg  <= pq3_next;
            pt3_reg  <= pt3_next;
        end
        if (adv[4])
        begin
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
            p4_reg   <= p_sum[2*CB-1:CB];
        end
        if (adv[5])
        begin
            sec5_reg <= sec4_reg;
            val5_reg <= val4_reg;
            p5_reg   <= p4_reg;
        end
        if (adv[6])
        begin
            rgb_reg  <= rgb_next;
        end
    end

endmodule
